>>> src/obb_sat_pkg.sv
// ----------------------------------------------------------------------------
// Oriented box overlap package
// Shared widths and helper functions for the separating axis test.
// ----------------------------------------------------------------------------
`default_nettype none

package obb_sat_pkg;

  localparam int unsigned CompBits  = 16;
  localparam int unsigned AxisFrac  = CompBits - 2;
  localparam int unsigned WordBits  = 3 * CompBits;
  // Center difference, one bit wider than a component.
  localparam int unsigned DiffBits  = CompBits + 1;
  // Dot product of an axis with D: three products of CompBits x DiffBits.
  localparam int unsigned TBits     = CompBits + DiffBits + 2;
  // Axis dot axis: three products of CompBits x CompBits.
  localparam int unsigned CBits     = 2 * CompBits + 2;
  // Wide compare width for both face and edge axes.
  localparam int unsigned WideBits  = TBits + CBits + AxisFrac + 4;

  typedef logic signed [CompBits-1:0] comp_t;
  typedef logic        [CompBits-1:0] ext_t;
  typedef logic signed [DiffBits-1:0] diff_t;
  typedef logic signed [TBits-1:0]    tdot_t;
  typedef logic signed [CBits-1:0]    cdot_t;
  typedef logic signed [WideBits-1:0] wide_t;

  // Signed component i of a packed word.
  function automatic comp_t comp_s(input logic [WordBits-1:0] w, input int unsigned i);
    return comp_t'(w[i*CompBits +: CompBits]);
  endfunction

  // Unsigned component i of a packed word.
  function automatic ext_t comp_u(input logic [WordBits-1:0] w, input int unsigned i);
    return w[i*CompBits +: CompBits];
  endfunction

  function automatic wide_t wabs(input wide_t v);
    return v[WideBits-1] ? -v : v;
  endfunction

  // Half extent times an axis dot product magnitude, at its natural width.
  function automatic wide_t mul_ek(input ext_t e, input cdot_t k);
    logic signed [CompBits+CBits:0] pr;
    pr = $signed({1'b0, e}) * k;
    return wide_t'(pr);
  endfunction

  // Projected center distance times an axis dot product.
  function automatic wide_t mul_tc(input tdot_t t, input cdot_t c);
    logic signed [TBits+CBits-1:0] pr;
    pr = t * c;
    return wide_t'(pr);
  endfunction

endpackage

`default_nettype wire

>>> src/obb_sat_lane.sv
// ----------------------------------------------------------------------------
// Separating axis lane
// Tests one axis: |dist| against the summed radii, registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_sat_lane import obb_sat_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire wide_t p0_i,
  input  wire wide_t p1_i,
  input  wire wide_t r0_i,
  input  wire wide_t r1_i,
  input  wire wide_t r2_i,
  input  wire wide_t r3_i,
  output logic       sep_o
);

  wide_t dist_d;
  wide_t rad_d;
  logic  sep_q;

  // Distance is the difference of two products; the radius is a sum of four.
  always_comb begin
    dist_d = wabs(p0_i - p1_i);
    rad_d  = r0_i + r1_i + r2_i + r3_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sep_q <= (dist_d > rad_d);
    end
  end

  assign sep_o = sep_q;

endmodule

`default_nettype wire

>>> src/obb_overlap_separating_axis.sv
// ----------------------------------------------------------------------------
// Oriented box overlap, separating axis test
// Fifteen lanes test all face and edge axes; a merge stage ORs them and inverts.
//
//   channel | signals                          | direction
//   in      | in_valid_i, in_stall_o, fields   | box pair in
//   out     | out_valid_o, out_stall_i, overlap| result out
//
// Five register stages: D, dot products, lane products, lane compare, merge.
// One pair per cycle while no stall holds the pipeline; a result passes all five.
// Reset clears the stage valid bits only.
// A stall holds the whole pipeline; the input stalls whenever a result waits
// at the output under a stall, even if earlier stages hold bubbles.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_overlap_separating_axis import obb_sat_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [WordBits-1:0] first_center_i,
  input  wire logic [WordBits-1:0] first_axis_x_i,
  input  wire logic [WordBits-1:0] first_axis_y_i,
  input  wire logic [WordBits-1:0] first_axis_z_i,
  input  wire logic [WordBits-1:0] first_extents_i,
  input  wire logic [WordBits-1:0] second_center_i,
  input  wire logic [WordBits-1:0] second_axis_x_i,
  input  wire logic [WordBits-1:0] second_axis_y_i,
  input  wire logic [WordBits-1:0] second_axis_z_i,
  input  wire logic [WordBits-1:0] second_extents_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     boxes_overlap_o
);

  logic [4:0] vld_q;
  logic       adv;

  // The pipeline moves unless a valid result is held at the output.
  assign adv        = !(out_stall_i && vld_q[4]);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  // Stage 1: center difference, axes, extents.
  logic [WordBits-1:0] axa [3];
  logic [WordBits-1:0] axb [3];
  diff_t d_q  [3];
  comp_t a_q  [3][3];
  comp_t b_q  [3][3];
  ext_t  ea_q [3];
  ext_t  eb_q [3];

  assign axa[0] = first_axis_x_i;
  assign axa[1] = first_axis_y_i;
  assign axa[2] = first_axis_z_i;
  assign axb[0] = second_axis_x_i;
  assign axb[1] = second_axis_y_i;
  assign axb[2] = second_axis_z_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i]  <= diff_t'(comp_s(second_center_i, i)) - diff_t'(comp_s(first_center_i, i));
        ea_q[i] <= comp_u(first_extents_i, i);
        eb_q[i] <= comp_u(second_extents_i, i);
        for (int j = 0; j < 3; j++) begin
          a_q[i][j] <= comp_s(axa[i], j);
          b_q[i][j] <= comp_s(axb[i], j);
        end
      end
    end
  end

  // Stage 2: dot products T and C.
  tdot_t ta_q [3];
  tdot_t tb_q [3];
  cdot_t c_q  [3][3];
  ext_t  ea2_q [3];
  ext_t  eb2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ta_q[i]  <= tdot_t'(a_q[i][0] * d_q[0]) + tdot_t'(a_q[i][1] * d_q[1])
                  + tdot_t'(a_q[i][2] * d_q[2]);
        tb_q[i]  <= tdot_t'(b_q[i][0] * d_q[0]) + tdot_t'(b_q[i][1] * d_q[1])
                  + tdot_t'(b_q[i][2] * d_q[2]);
        ea2_q[i] <= ea_q[i];
        eb2_q[i] <= eb_q[i];
        for (int j = 0; j < 3; j++) begin
          c_q[i][j] <= cdot_t'(a_q[i][0] * b_q[j][0]) + cdot_t'(a_q[i][1] * b_q[j][1])
                     + cdot_t'(a_q[i][2] * b_q[j][2]);
        end
      end
    end
  end

  // Absolute values of C, derived combinationally from stage 2.
  cdot_t kw [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        kw[i][j] = c_q[i][j][CBits-1] ? -c_q[i][j] : c_q[i][j];
      end
    end
  end

  // Stage 3: lane operands, each product registered before the compare.
  wide_t p0_q [15];
  wide_t p1_q [15];
  wide_t r0_q [15];
  wide_t r1_q [15];
  wide_t r2_q [15];
  wide_t r3_q [15];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        // Face axis of the first box.
        p0_q[i]   <= wide_t'(ta_q[i]) <<< AxisFrac;
        p1_q[i]   <= '0;
        r0_q[i]   <= wide_t'(ea2_q[i]) <<< (2 * AxisFrac);
        r1_q[i]   <= mul_ek(eb2_q[0], kw[i][0]);
        r2_q[i]   <= mul_ek(eb2_q[1], kw[i][1]);
        r3_q[i]   <= mul_ek(eb2_q[2], kw[i][2]);
        // Face axis of the second box.
        p0_q[3+i] <= wide_t'(tb_q[i]) <<< AxisFrac;
        p1_q[3+i] <= '0;
        r0_q[3+i] <= wide_t'(eb2_q[i]) <<< (2 * AxisFrac);
        r1_q[3+i] <= mul_ek(ea2_q[0], kw[0][i]);
        r2_q[3+i] <= mul_ek(ea2_q[1], kw[1][i]);
        r3_q[3+i] <= mul_ek(ea2_q[2], kw[2][i]);
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p0_q[6+3*i+j] <= mul_tc(ta_q[(i+2)%3], c_q[(i+1)%3][j]);
          p1_q[6+3*i+j] <= mul_tc(ta_q[(i+1)%3], c_q[(i+2)%3][j]);
          r0_q[6+3*i+j] <= mul_ek(ea2_q[(i+1)%3], kw[(i+2)%3][j]) <<< AxisFrac;
          r1_q[6+3*i+j] <= mul_ek(ea2_q[(i+2)%3], kw[(i+1)%3][j]) <<< AxisFrac;
          r2_q[6+3*i+j] <= mul_ek(eb2_q[(j+1)%3], kw[i][(j+2)%3]) <<< AxisFrac;
          r3_q[6+3*i+j] <= mul_ek(eb2_q[(j+2)%3], kw[i][(j+1)%3]) <<< AxisFrac;
        end
      end
    end
  end

  // Fifteen lanes, each registering its own separation flag.
  logic [14:0] sep;
  for (genvar g = 0; g < 15; g++) begin : g_lane
    obb_sat_lane u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .p0_i  (p0_q[g]),
      .p1_i  (p1_q[g]),
      .r0_i  (r0_q[g]),
      .r1_i  (r1_q[g]),
      .r2_i  (r2_q[g]),
      .r3_i  (r3_q[g]),
      .sep_o (sep[g])
    );
  end

  // Stage 5: merge; any separating axis means no overlap.
  logic ovl_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ovl_q <= ~|sep;
    end
  end

  assign out_valid_o     = vld_q[4];
  assign boxes_overlap_o = ovl_q;

endmodule

`default_nettype wire
